FILE: hw/rtl/ymsg_pkg.sv
// Shared types and constants for the YMSG header deframer.
// Holds phase codes, magic bytes and the result record type.
// No dependencies.
`timescale 1ns / 1ps

package ymsg_pkg;

    localparam int PHASE_W = 5;

    localparam logic [PHASE_W-1:0] PH_HUNT_Y     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT_G     = 5'd3;
    localparam logic [PHASE_W-1:0] PH_VERSION_LO = 5'd5;
    localparam logic [PHASE_W-1:0] PH_SKIP_LO    = 5'd7;
    localparam logic [PHASE_W-1:0] PH_LENGTH_LO  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_SERVICE_LO = 5'd11;
    localparam logic [PHASE_W-1:0] PH_STATUS_LO  = 5'd15;
    localparam logic [PHASE_W-1:0] PH_SESSION_LO = 5'd19;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD    = 5'd20;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef logic [7:0] byte_t;

    function automatic byte_t magic_byte(input logic [1:0] idx);
        byte_t b;
        case (idx)
            2'd0:    b = 8'h59;
            2'd1:    b = 8'h4D;
            2'd2:    b = 8'h53;
            2'd3:    b = 8'h47;
            default: b = 8'h59;
        endcase
        return b;
    endfunction

    typedef struct packed {
        logic        kind;
        logic [15:0] version;
        logic [15:0] payload_length;
        logic [15:0] service;
        logic [31:0] status;
        logic [31:0] session_word;
        logic [7:0]  payload_byte;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_msg_t;

endpackage

FILE: hw/rtl/ymsg_parser.sv
// Header parser: phase counter and header field registers, plus the
// result that the current byte produces. Depends on ymsg_pkg.
`timescale 1ns / 1ps

module ymsg_parser
    import ymsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  byte_t       data_byte,
    output result_msg_t result
);

    logic [PHASE_W-1:0] phase_reg, phase_next, p;
    logic [15:0]        version_reg, version_next;
    logic [15:0]        bytes_left_reg, bytes_left_next;
    logic [15:0]        service_reg, service_next;
    logic [31:0]        status_reg, status_next;
    logic [31:0]        session_reg, session_next;
    logic [15:0]        left_dec;

    assign left_dec = bytes_left_reg - 16'd1;

    always_comb
    begin
        p               = (phase_reg > PH_PAYLOAD) ? PH_HUNT_Y : phase_reg;
        phase_next      = p + 5'd1;
        version_next    = version_reg;
        bytes_left_next = bytes_left_reg;
        service_next    = service_reg;
        status_next     = status_reg;
        session_next    = session_reg;
        result          = '0;

        if (p <= PH_HUNT_G) begin
            if (data_byte != magic_byte(p[1:0])) begin
                phase_next = PH_HUNT_Y;
            end
        end else if (p <= PH_VERSION_LO) begin
            version_next = {version_reg[7:0], data_byte};
        end else if (p <= PH_SKIP_LO) begin
            phase_next = p + 5'd1;
        end else if (p <= PH_LENGTH_LO) begin
            bytes_left_next = {bytes_left_reg[7:0], data_byte};
        end else if (p <= PH_SERVICE_LO) begin
            service_next = {service_reg[7:0], data_byte};
        end else if (p <= PH_STATUS_LO) begin
            status_next = {status_reg[23:0], data_byte};
        end else if (p <= PH_SESSION_LO) begin
            session_next = {session_reg[23:0], data_byte};
            if (p == PH_SESSION_LO) begin
                result.valid               = 1'b1;
                result.data.kind           = KIND_HEADER;
                result.data.version        = version_reg;
                result.data.payload_length = bytes_left_reg;
                result.data.service        = service_reg;
                result.data.status         = status_reg;
                result.data.session_word   = session_next;
                result.data.last           = (bytes_left_reg == 16'd0);
                phase_next = (bytes_left_reg == 16'd0) ? PH_HUNT_Y : PH_PAYLOAD;
            end
        end else begin
            bytes_left_next          = left_dec;
            result.valid             = 1'b1;
            result.data.kind         = KIND_PAYLOAD;
            result.data.payload_byte = data_byte;
            result.data.last         = (left_dec == 16'd0);
            phase_next = (left_dec == 16'd0) ? PH_HUNT_Y : PH_PAYLOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_HUNT_Y;
            version_reg    <= '0;
            bytes_left_reg <= '0;
            service_reg    <= '0;
            status_reg     <= '0;
            session_reg    <= '0;
        end else if (fire) begin
            phase_reg      <= phase_next;
            version_reg    <= version_next;
            bytes_left_reg <= bytes_left_next;
            service_reg    <= service_next;
            status_reg     <= status_next;
            session_reg    <= session_next;
        end
    end

endmodule

FILE: hw/rtl/ymsg_out_buf.sv
// Two-entry result buffer that registers every result and decouples
// the output ready from the input side. Depends on ymsg_pkg.
`timescale 1ns / 1ps

module ymsg_out_buf
    import ymsg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t     entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/ymsg_header_deframer_unit.sv
// Top level of the YMSG header deframer.
// Instantiates ymsg_parser and ymsg_out_buf; depends on ymsg_pkg.
`timescale 1ns / 1ps

// One stream byte is taken per clock whenever the two-entry result buffer
// has room, so the block sustains one item per cycle. The parser hunts for
// "YMSG", collects the 20-byte header and emits one header result, then one
// result per payload byte with last set on the final one. Each result is
// registered in the buffer and reaches the output only after its byte is
// accepted. Use one instance per stream direction.
module ymsg_header_deframer_unit
    import ymsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [15:0] version,
    output logic [15:0] payload_length,
    output logic [15:0] service,
    output logic [31:0] status,
    output logic [31:0] session_word,
    output logic [7:0]  payload_byte,
    output logic        last
);

    logic        fire;
    logic        space;
    result_msg_t result;
    result_t     out_data;

    assign in_ready = space;
    assign fire     = in_valid && in_ready;

    ymsg_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_byte),
        .result    (result)
    );

    ymsg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && result.valid),
        .push_data (result.data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign version        = out_data.version;
    assign payload_length = out_data.payload_length;
    assign service        = out_data.service;
    assign status         = out_data.status;
    assign session_word   = out_data.session_word;
    assign payload_byte   = out_data.payload_byte;
    assign last           = out_data.last;

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input stalled while the result buffer is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_HEADER |-> payload_byte == 8'd0)
        else $error("Header result carries a payload byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PAYLOAD |->
            version == 16'd0 && payload_length == 16'd0 && status == 32'd0)
        else $error("Payload result carries header fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.valid && result.data.kind == KIND_HEADER |=> out_valid)
        else $error("Header result was not buffered.");

endmodule

FILE: verif/ymsg_deframer_checker.sv
// Scoreboard for the YMSG header deframer: watches both channels and predicts results.
// Holds its own copy of the parser state and compares each result field by field.
// Depends on ymsg_pkg.
`timescale 1ns / 1ps

module ymsg_deframer_checker
    import ymsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [15:0] version,
    input  logic [15:0] payload_length,
    input  logic [15:0] service,
    input  logic [31:0] status,
    input  logic [31:0] session_word,
    input  logic [7:0]  payload_byte,
    input  logic        last,
    output int          fail_count,
    output int          pending,
    output int          headers_seen,
    output int          payload_seen
);

    localparam logic [31:0] SYNC_WORD = 32'h594D_5347;
    localparam int PRINT_CAP = 40;

    logic [PHASE_W-1:0] parse_phase;
    logic [15:0]        version_q;
    logic [15:0]        length_left;
    logic [15:0]        service_q;
    logic [31:0]        status_q;
    logic [31:0]        session_q;
    result_t            expected_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH @%0t: %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    function automatic bit parse_byte(input byte_t b, output result_t r);
        logic [PHASE_W-1:0] p;
        p = (parse_phase > PH_PAYLOAD) ? PH_HUNT_Y : parse_phase;
        r = '0;
        parse_byte = 1'b0;
        if (p <= PH_HUNT_G) begin
            parse_phase = (b == SYNC_WORD[31 - 8 * p[1:0] -: 8]) ? p + 5'd1 : PH_HUNT_Y;
        end
        else if (p <= PH_VERSION_LO) begin
            version_q = {version_q[7:0], b};
            parse_phase = p + 5'd1;
        end
        else if (p <= PH_SKIP_LO) begin
            parse_phase = p + 5'd1;
        end
        else if (p <= PH_LENGTH_LO) begin
            length_left = {length_left[7:0], b};
            parse_phase = p + 5'd1;
        end
        else if (p <= PH_SERVICE_LO) begin
            service_q = {service_q[7:0], b};
            parse_phase = p + 5'd1;
        end
        else if (p <= PH_STATUS_LO) begin
            status_q = {status_q[23:0], b};
            parse_phase = p + 5'd1;
        end
        else if (p < PH_SESSION_LO) begin
            session_q = {session_q[23:0], b};
            parse_phase = p + 5'd1;
        end
        else if (p == PH_SESSION_LO) begin
            session_q = {session_q[23:0], b};
            r.kind = KIND_HEADER;
            r.version = version_q;
            r.payload_length = length_left;
            r.service = service_q;
            r.status = status_q;
            r.session_word = session_q;
            r.last = (length_left == 16'd0);
            parse_phase = r.last ? PH_HUNT_Y : PH_PAYLOAD;
            parse_byte = 1'b1;
        end
        else begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            length_left = length_left - 16'd1;
            r.last = (length_left == 16'd0);
            parse_phase = r.last ? PH_HUNT_Y : PH_PAYLOAD;
            parse_byte = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            parse_phase = PH_HUNT_Y;
            version_q = '0;
            length_left = '0;
            service_q = '0;
            status_q = '0;
            session_q = '0;
            expected_results.delete();
            pending = 0;
            fail_count = 0;
            headers_seen = 0;
            payload_seen = 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 32'd0, {31'd0, kind});
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("version", 32'(want.version), 32'(version));
                    check_field("payload_length", 32'(want.payload_length),
                                32'(payload_length));
                    check_field("service", 32'(want.service), 32'(service));
                    check_field("status", want.status, status);
                    check_field("session_word", want.session_word, session_word);
                    check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
                    check_field("last", 32'(want.last), 32'(last));
                    if (want.kind == KIND_HEADER)
                        headers_seen++;
                    else
                        payload_seen++;
                end
            end
            if (in_valid && in_ready === 1'b1)
            begin
                if (parse_byte(data_byte, fresh))
                    expected_results.push_back(fresh);
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: verif/ymsg_header_deframer_unit_test.sv
// Testbench top for ymsg_header_deframer_unit: drives framed and broken byte streams.
// Depends on ymsg_pkg, ymsg_header_deframer_unit and ymsg_deframer_checker.
`timescale 1ns / 1ps

module ymsg_header_deframer_unit_test;
    import ymsg_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES = 130;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [15:0] version;
    logic [15:0] payload_length;
    logic [15:0] service;
    logic [31:0] status;
    logic [31:0] session_word;
    logic [7:0]  payload_byte;
    logic        last;

    int          fail_count;
    int          pending;
    int          headers_seen;
    int          payload_seen;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          bytes_sent = 0;
    int          messages_sent = 0;
    int unsigned cycle_count = 0;

    ymsg_header_deframer_unit u_top (.*);

    ymsg_deframer_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ymsg_header_deframer_unit test failed");
        $finish;
    end

    task automatic send_byte(input byte_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_message(input logic [15:0] ver, input logic [15:0] len,
                                input logic [15:0] svc, input logic [31:0] stat,
                                input logic [31:0] sess);
        for (int i = 0; i < 4; i++)
            send_byte(magic_byte(i[1:0]));
        send_byte(ver[15:8]);
        send_byte(ver[7:0]);
        send_byte(byte_t'($urandom));
        send_byte(byte_t'($urandom));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(svc[15:8]);
        send_byte(svc[7:0]);
        for (int i = 3; i >= 0; i--)
            send_byte(stat[8 * i +: 8]);
        for (int i = 3; i >= 0; i--)
            send_byte(sess[8 * i +: 8]);
        for (int i = 0; i < len; i++)
            send_byte(byte_t'($urandom));
        messages_sent++;
    endtask

    task automatic send_noise();
        int count;
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_byte(magic_byte(2'd0));
            else
                send_byte(byte_t'($urandom));
        end
    endtask

    task automatic send_broken_magic();
        int depth;
        depth = $urandom_range(1, 3);
        for (int i = 0; i < depth; i++)
            send_byte(magic_byte(i[1:0]));
        send_byte(magic_byte(depth[1:0]) ^ byte_t'($urandom_range(1, 255)));
    endtask

    task automatic send_random_message();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            len = $urandom_range(0, 3);
        else if (pick < 85)
            len = $urandom_range(4, 16);
        else
            len = $urandom_range(17, 60);
        send_message(16'($urandom), 16'(len), 16'($urandom), $urandom, $urandom);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int start;
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_random_message();
            else if (pick < 90)
                send_noise();
            else
                send_broken_magic();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(magic_byte(2'd0));
        send_byte(magic_byte(2'd0));
        send_byte(magic_byte(2'd1));
        send_message(16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        run_phase(0, 0, PHASE_BYTES);
        send_message(16'h0000, 16'h0020, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        run_phase(72, 0, PHASE_BYTES);
        run_phase(0, 72, PHASE_BYTES);
        run_phase(21, 21, PHASE_BYTES);

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d bytes carrying %0d framed messages under four pacing mixes.",
                 bytes_sent, messages_sent);
        $display("Compared %0d header results and %0d payload results.",
                 headers_seen, payload_seen);
        if (fail_count == 0)
            $display("ymsg_header_deframer_unit test passed");
        else
            $display("ymsg_header_deframer_unit test failed");
        $finish;
    end

endmodule

FILE: ymsg_header_deframer_unit.f
hw/rtl/ymsg_pkg.sv
hw/rtl/ymsg_parser.sv
hw/rtl/ymsg_out_buf.sv
hw/rtl/ymsg_header_deframer_unit.sv
verif/ymsg_deframer_checker.sv
verif/ymsg_header_deframer_unit_test.sv
